@@ src/stp_pkg.sv @@
package stp_pkg;

    // Operation codes of an input item
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Error codes of a result item
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_ZERO_SPEED = 2'd1;
    localparam logic [1:0] ERR_BUSY       = 2'd2;
    localparam logic [1:0] ERR_ZERO_STEPS = 2'd3;

    localparam int COIL_COUNT   = 4;
    localparam int SPR_W        = 16;
    localparam int SPEED_W      = 10;
    localparam int COUNT_W      = 32;
    localparam int TICK_W       = 26;
    localparam int DIV_STEPS    = TICK_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    localparam logic [SPR_W-1:0]  SPR_RESET      = 16'd2048;
    localparam logic [TICK_W-1:0] TICKS_PER_MIN  = 26'd60000000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch_start;
        logic respond_now;
        logic mul;
        logic div_step;
        logic commit;
    } stp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic start_ok;
        logic out_free;
    } stp_status_t;

    // Full-step coil pattern for a phase
    function automatic logic [COIL_COUNT-1:0] phase_pattern(input logic [1:0] phase);
        logic [COIL_COUNT-1:0] pat;
        unique case (phase)
            2'd0:    pat = 4'd5;
            2'd1:    pat = 4'd6;
            2'd2:    pat = 4'd10;
            default: pat = 4'd9;
        endcase
        return pat;
    endfunction

endpackage

@@ src/stp_ctrl.sv @@
module stp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                operation,
    input  stp_pkg::stp_status_t status,
    output logic                in_stall,
    output stp_pkg::stp_cmd_t   cmd
);
    import stp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  accept;
    logic                  go_start;

    // Accept only when idle and the output register can take a result
    assign accept   = in_valid && (state_reg == S_IDLE) && status.out_free;
    assign in_stall = !((state_reg == S_IDLE) && status.out_free);
    assign go_start = accept && (operation == OP_START) && status.start_ok;

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmd.latch_start = 1'b0;
        cmd.respond_now = 1'b0;
        cmd.mul         = 1'b0;
        cmd.div_step    = 1'b0;
        cmd.commit      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go_start)
                begin
                    cmd.latch_start = 1'b1;
                    state_next      = S_MUL;
                end
                else if (accept)
                begin
                    cmd.respond_now = 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("commit while output register is full");

    a_start_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        go_start |=> state_reg == S_MUL)
        else $error("accepted start did not enter multiply");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg <= DIV_CNT_W'(DIV_STEPS - 1))
        else $error("division step counter out of range");

endmodule

@@ src/stp_dp.sv @@
module stp_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [stp_pkg::SPR_W-1:0]     cfg_wr_data,
    input  logic                          operation,
    input  logic [stp_pkg::COUNT_W-1:0]   step_count,
    input  logic [stp_pkg::SPEED_W-1:0]   speed_rpm,
    input  logic                          direction,
    input  stp_pkg::stp_cmd_t             cmd,
    output stp_pkg::stp_status_t          status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [stp_pkg::COIL_COUNT-1:0] coils,
    output logic                          step_taken,
    output logic                          busy_res,
    output logic                          move_done,
    output logic [1:0]                    error_code
);
    import stp_pkg::*;

    // Configuration and move state
    logic [SPR_W-1:0]      spr_reg;
    logic                  active_reg, active_next;
    logic [COUNT_W-1:0]    steps_left_reg, steps_left_next;
    logic [TICK_W-1:0]     reload_reg, reload_next;
    logic [TICK_W-1:0]     countdown_reg, countdown_next;
    logic [SPR_W-1:0]      position_reg, position_next;
    logic                  dir_reg, dir_next;
    logic [COIL_COUNT-1:0] coil_reg, coil_next;

    // Latched start command and divider
    logic [COUNT_W-1:0]    count_hold_reg;
    logic [SPEED_W-1:0]    speed_hold_reg;
    logic                  dir_hold_reg;
    logic [TICK_W-1:0]     divisor_reg;
    logic [TICK_W-1:0]     rem_reg;
    logic [TICK_W-1:0]     quo_reg;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [COIL_COUNT-1:0] out_coils_reg, out_coils_next;
    logic                  out_step_reg, out_step_next;
    logic                  out_busy_reg, out_busy_next;
    logic                  out_done_reg, out_done_next;
    logic [1:0]            out_err_reg, out_err_next;

    logic [SPR_W-1:0]      modulus;
    logic [TICK_W:0]       rem_shift;
    logic                  quo_bit;
    logic [TICK_W-1:0]     cd_dec;
    logic [SPR_W:0]        pos_inc;
    logic [SPR_W-1:0]      pos_step;
    logic [COUNT_W-1:0]    steps_dec;
    logic                  load_out;

    assign modulus = (spr_reg == '0) ? SPR_W'(1) : spr_reg;

    // Status toward the controller
    assign status.start_ok = !active_reg && (speed_rpm != '0) && (step_count != '0);
    assign status.out_free = !out_valid_reg || !out_stall;

    // Restoring division step
    assign rem_shift = {rem_reg, quo_reg[TICK_W-1]};
    assign quo_bit   = rem_shift >= {1'b0, divisor_reg};

    // One step of position, wrapping at the modulus
    assign pos_inc = {1'b0, position_reg} + 1'b1;
    always_comb
    begin
        if (dir_reg == 1'b0)
        begin
            pos_step = (pos_inc >= {1'b0, modulus}) ? '0 : pos_inc[SPR_W-1:0];
        end
        else
        begin
            pos_step = (position_reg == '0) ? (modulus - 1'b1) : (position_reg - 1'b1);
        end
    end

    assign cd_dec    = (countdown_reg == '0) ? '0 : (countdown_reg - 1'b1);
    assign steps_dec = steps_left_reg - 1'b1;
    assign load_out  = cmd.respond_now || cmd.commit;

    // Move state and result fields
    always_comb
    begin
        active_next     = active_reg;
        steps_left_next = steps_left_reg;
        reload_next     = reload_reg;
        countdown_next  = countdown_reg;
        position_next   = position_reg;
        dir_next        = dir_reg;
        coil_next       = coil_reg;
        out_step_next   = 1'b0;
        out_done_next   = 1'b0;
        out_err_next    = ERR_NONE;
        if (cmd.commit)
        begin
            reload_next     = (quo_reg == '0) ? TICK_W'(1) : quo_reg;
            countdown_next  = (quo_reg == '0) ? TICK_W'(1) : quo_reg;
            steps_left_next = count_hold_reg;
            position_next   = '0;
            dir_next        = dir_hold_reg;
            active_next     = 1'b1;
        end
        else if (cmd.respond_now)
        begin
            if (operation == OP_START)
            begin
                priority if (active_reg)
                    out_err_next = ERR_BUSY;
                else if (speed_rpm == '0)
                    out_err_next = ERR_ZERO_SPEED;
                else
                    out_err_next = ERR_ZERO_STEPS;
            end
            else if (active_reg)
            begin
                countdown_next = cd_dec;
                if (cd_dec == '0)
                begin
                    position_next   = pos_step;
                    coil_next       = phase_pattern(pos_step[1:0]);
                    out_step_next   = 1'b1;
                    steps_left_next = steps_dec;
                    countdown_next  = reload_reg;
                    if (steps_dec == '0)
                    begin
                        active_next   = 1'b0;
                        out_done_next = 1'b1;
                    end
                end
            end
        end
        out_coils_next = coil_next;
        out_busy_next  = active_next;
    end

    // Output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // Hold control and move state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg        <= SPR_RESET;
            active_reg     <= 1'b0;
            steps_left_reg <= '0;
            reload_reg     <= '0;
            countdown_reg  <= '0;
            position_reg   <= '0;
            dir_reg        <= 1'b0;
            coil_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                spr_reg <= cfg_wr_data;
            active_reg     <= active_next;
            steps_left_reg <= steps_left_next;
            reload_reg     <= reload_next;
            countdown_reg  <= countdown_next;
            position_reg   <= position_next;
            dir_reg        <= dir_next;
            coil_reg       <= coil_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Capture command, multiply, divide, and load the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_start)
        begin
            count_hold_reg <= step_count;
            speed_hold_reg <= speed_rpm;
            dir_hold_reg   <= direction;
        end
        if (cmd.mul)
        begin
            divisor_reg <= TICK_W'(modulus * speed_hold_reg);
            rem_reg     <= '0;
            quo_reg     <= TICKS_PER_MIN;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= quo_bit ? TICK_W'(rem_shift - {1'b0, divisor_reg})
                               : rem_shift[TICK_W-1:0];
            quo_reg <= {quo_reg[TICK_W-2:0], quo_bit};
        end
        if (load_out)
        begin
            out_coils_reg <= out_coils_next;
            out_step_reg  <= out_step_next;
            out_busy_reg  <= out_busy_next;
            out_done_reg  <= out_done_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign coils      = out_coils_reg;
    assign step_taken = out_step_reg;
    assign busy_res   = out_busy_reg;
    assign move_done  = out_done_reg;
    assign error_code = out_err_reg;

    a_reload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> reload_reg != '0)
        else $error("active move with zero tick reload");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> !out_busy_reg && out_step_reg)
        else $error("move_done without final step");

endmodule

@@ src/stepper_full_step_sequencer.sv @@
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  operation, step_count, speed_rpm, direction
// out       source     out_valid / out_stall coils, step_taken, busy_res, move_done, error_code
// cfg       sink       cfg_wr_en            cfg_wr_data (steps per revolution)
//
// A tick or a rejected start is answered straight from the idle state; an accepted start
// goes through capture, one 16x10 multiply, 26 restoring division steps on the
// one-bit-per-cycle divider, and commit. One item is worked on at a time.
// Reset is asynchronous, active low; no clearing pass is needed.
// A result waits in the output register while out_stall is high; a new item is
// taken in the same cycle that the waiting result transfers.
module stepper_full_step_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [stp_pkg::SPR_W-1:0]      cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic [stp_pkg::COUNT_W-1:0]    step_count,
    input  logic [stp_pkg::SPEED_W-1:0]    speed_rpm,
    input  logic                           direction,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [stp_pkg::COIL_COUNT-1:0] coils,
    output logic                           step_taken,
    output logic                           busy_res,
    output logic                           move_done,
    output logic [1:0]                     error_code
);
    import stp_pkg::*;

    stp_cmd_t    cmd;
    stp_status_t status;

    // Sequence the start computation and response timing
    stp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .status    (status),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    // Hold the move state, divider and output register
    stp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .operation   (operation),
        .step_count  (step_count),
        .speed_rpm   (speed_rpm),
        .direction   (direction),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .coils       (coils),
        .step_taken  (step_taken),
        .busy_res    (busy_res),
        .move_done   (move_done),
        .error_code  (error_code)
    );

endmodule

@@ tb/coil_motion_checker.sv @@
module coil_motion_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [stp_pkg::SPR_W-1:0]      cfg_wr_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           operation,
    input  logic [stp_pkg::COUNT_W-1:0]    step_count,
    input  logic [stp_pkg::SPEED_W-1:0]    speed_rpm,
    input  logic                           direction,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [stp_pkg::COIL_COUNT-1:0] coils,
    input  logic                           step_taken,
    input  logic                           busy_res,
    input  logic                           move_done,
    input  logic [1:0]                     error_code,
    output int                             fail_count,
    output int                             exp_pending
);

    localparam logic [31:0] MICROS_PER_MINUTE = 32'd60_000_000;
    // Coil patterns for phases 0..3, phase 0 in the low nibble
    localparam logic [15:0] PHASE_COILS = {4'd9, 4'd10, 4'd6, 4'd5};

    typedef struct packed {
        logic [stp_pkg::COIL_COUNT-1:0] coils;
        logic                           step_taken;
        logic                           busy_res;
        logic                           move_done;
        logic [1:0]                     error_code;
    } motion_res_t;

    // Shadow of the block's state
    logic [stp_pkg::SPR_W-1:0]   spr_q;
    logic                        moving;
    logic [stp_pkg::COUNT_W-1:0] steps_rem;
    logic [stp_pkg::TICK_W-1:0]  reload_q;
    logic [stp_pkg::TICK_W-1:0]  countdown_q;
    logic [15:0]                 pos_q;
    logic                        dir_q;
    logic [3:0]                  coil_q;

    motion_res_t coil_results_due[$];
    motion_res_t want;
    int          fails = 0;

    // Work out the result of one item and advance the shadow state
    function automatic motion_res_t advance_motor(input logic op, input logic [31:0] cnt,
                                                  input logic [9:0] spd, input logic dir);
        motion_res_t res;
        logic [31:0] wrap;
        logic [31:0] divisor;
        logic [31:0] span;
        logic [31:0] nxt;
        res = '0;
        wrap = (spr_q == 16'd0) ? 32'd1 : {16'd0, spr_q};
        if (op == stp_pkg::OP_START)
        begin
            if (moving)
                res.error_code = stp_pkg::ERR_BUSY;
            else if (spd == 10'd0)
                res.error_code = stp_pkg::ERR_ZERO_SPEED;
            else if (cnt == 32'd0)
                res.error_code = stp_pkg::ERR_ZERO_STEPS;
            else
            begin
                divisor = wrap * {22'd0, spd};
                span = MICROS_PER_MINUTE / divisor;
                if (span == 32'd0)
                    span = 32'd1;
                reload_q = span[stp_pkg::TICK_W-1:0];
                countdown_q = reload_q;
                steps_rem = cnt;
                pos_q = 16'd0;
                dir_q = dir;
                moving = 1'b1;
            end
        end
        else if (moving)
        begin
            if (countdown_q != '0)
                countdown_q = countdown_q - 1'b1;
            if (countdown_q == '0)
            begin
                // step with the modulus in force now
                if (dir_q == 1'b0)
                begin
                    nxt = {16'd0, pos_q} + 32'd1;
                    pos_q = (nxt >= wrap) ? 16'd0 : nxt[15:0];
                end
                else if (pos_q == 16'd0)
                    pos_q = wrap[15:0] - 16'd1;
                else
                    pos_q = pos_q - 16'd1;
                coil_q = PHASE_COILS[pos_q[1:0]*4 +: 4];
                res.step_taken = 1'b1;
                steps_rem = steps_rem - 32'd1;
                countdown_q = reload_q;
                if (steps_rem == 32'd0)
                begin
                    moving = 1'b0;
                    res.move_done = 1'b1;
                end
            end
        end
        res.coils = coil_q;
        res.busy_res = moving;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_q = stp_pkg::SPR_RESET;
            moving = 1'b0;
            steps_rem = '0;
            reload_q = '0;
            countdown_q = '0;
            pos_q = '0;
            dir_q = 1'b0;
            coil_q = '0;
            coil_results_due.delete();
            exp_pending <= 0;
        end
        else
        begin
            // Track register writes
            if (cfg_wr_en)
                spr_q = cfg_wr_data;

            // Compare each result transfer with the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (coil_results_due.size() == 0)
                begin
                    $error("unexpected result: coils %0d error_code %0d", coils, error_code);
                    fails++;
                end
                else
                begin
                    want = coil_results_due.pop_front();
                    if (coils !== want.coils)
                    begin
                        $error("coils: expected %0d, actual %0d", want.coils, coils);
                        fails++;
                    end
                    if (step_taken !== want.step_taken)
                    begin
                        $error("step_taken: expected %0d, actual %0d", want.step_taken,
                               step_taken);
                        fails++;
                    end
                    if (busy_res !== want.busy_res)
                    begin
                        $error("busy_res: expected %0d, actual %0d", want.busy_res, busy_res);
                        fails++;
                    end
                    if (move_done !== want.move_done)
                    begin
                        $error("move_done: expected %0d, actual %0d", want.move_done, move_done);
                        fails++;
                    end
                    if (error_code !== want.error_code)
                    begin
                        $error("error_code: expected %0d, actual %0d", want.error_code,
                               error_code);
                        fails++;
                    end
                end
            end

            // Predict every input transfer
            if (in_valid && !in_stall)
                coil_results_due.push_back(advance_motor(operation, step_count, speed_rpm,
                                                         direction));

            exp_pending <= coil_results_due.size();
        end
    end

    always @(posedge clk)
    begin
        fail_count <= fails;
    end

endmodule

@@ tb/tb_stepper_full_step_sequencer.sv @@
module tb_stepper_full_step_sequencer;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [stp_pkg::SPR_W-1:0]      cfg_wr_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           operation = stp_pkg::OP_TICK;
    logic [stp_pkg::COUNT_W-1:0]    step_count = '0;
    logic [stp_pkg::SPEED_W-1:0]    speed_rpm = '0;
    logic                           direction = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [stp_pkg::COIL_COUNT-1:0] coils;
    logic                           step_taken;
    logic                           busy_res;
    logic                           move_done;
    logic [1:0]                     error_code;

    int fail_count;
    int exp_pending;

    int          gap_pct = 0;
    int          stall_pct = 0;
    int          sent_cnt = 0;
    logic [15:0] cur_spr = stp_pkg::SPR_RESET;

    stepper_full_step_sequencer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .step_count  (step_count),
        .speed_rpm   (speed_rpm),
        .direction   (direction),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .coils       (coils),
        .step_taken  (step_taken),
        .busy_res    (busy_res),
        .move_done   (move_done),
        .error_code  (error_code)
    );

    coil_motion_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .step_count  (step_count),
        .speed_rpm   (speed_rpm),
        .direction   (direction),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .coils       (coils),
        .step_taken  (step_taken),
        .busy_res    (busy_res),
        .move_done   (move_done),
        .error_code  (error_code),
        .fail_count  (fail_count),
        .exp_pending (exp_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at the rate of the current phase
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Ticks per step for a modulus and speed; plans the length of a move
    function automatic int unsigned ticks_per_step(input logic [15:0] spr,
                                                   input int unsigned spd);
        int unsigned m;
        int unsigned span;
        m = (spr == 16'd0) ? 1 : spr;
        span = 60000000 / (m * spd);
        return (span == 0) ? 1 : span;
    endfunction

    function automatic logic [15:0] pick_modulus();
        logic [15:0] m;
        case ($urandom_range(0, 6))
            0:       m = 16'd0;
            1:       m = 16'd1;
            2:       m = 16'd2;
            3:       m = 16'd3;
            4:       m = 16'hFFFF;
            5:       m = 16'd2048;
            default: m = 16'($urandom_range(1, 65535));
        endcase
        return m;
    endfunction

    // Offer one item and hold it until the transfer
    task automatic push_item(input logic op, input logic [31:0] cnt, input logic [9:0] spd,
                             input logic dir);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        step_count <= cnt;
        speed_rpm <= spd;
        direction <= dir;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_cnt++;
    endtask

    // Timer tick with junk in the unused fields
    task automatic random_tick();
        push_item(stp_pkg::OP_TICK, $urandom, 10'($urandom_range(0, 1023)),
                  1'($urandom_range(0, 1)));
    endtask

    // Hold off the sender until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (exp_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_spr(input logic [15:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_spr = value;
    endtask

    // Start a move and tick it to the end; optionally swap the modulus partway
    task automatic run_move(input int unsigned cnt, input int unsigned spd, input logic dir,
                            input int unsigned split, input logic [15:0] late_spr);
        int unsigned total;
        int unsigned i;
        total = ticks_per_step(cur_spr, spd) * cnt;
        push_item(stp_pkg::OP_START, cnt, 10'(spd), dir);
        for (i = 0; i < total; i++)
        begin
            if (split > 0 && i == split)
                write_spr(late_spr);
            // a start here is always refused: at least one step is left
            if ($urandom_range(0, 99) < 4)
                push_item(stp_pkg::OP_START, $urandom, 10'($urandom_range(0, 1023)),
                          1'($urandom_range(0, 1)));
            random_tick();
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int          pick;
        int          ph;
        int          phase_end;
        int unsigned m_eff;
        int unsigned speed_min;
        int unsigned spd;
        int unsigned span;
        int unsigned cnt;
        logic [15:0] phase_spr;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Rejections and an idle tick at reset settings
        random_tick();
        push_item(stp_pkg::OP_START, 32'hFFFF_FFFF, 10'd0, 1'b1);
        push_item(stp_pkg::OP_START, 32'd0, 10'd1023, 1'b0);
        push_item(stp_pkg::OP_START, 32'd0, 10'd0, 1'b0);

        // Busy check wins over the zero speed check
        write_spr(16'hFFFF);
        push_item(stp_pkg::OP_START, 32'd2, 10'd1023, 1'b0);
        push_item(stp_pkg::OP_START, 32'hFFFF_FFFF, 10'd0, 1'b1);
        random_tick();
        random_tick();
        random_tick();

        // Ticks per step clamp to one; count down through zero
        run_move(6, 1023, 1'b0, 0, 16'd0);
        run_move(3, 1023, 1'b1, 0, 16'd0);
        // Shrink the modulus below the position, then zero it, mid-move
        run_move(10, 1023, 1'b0, 5, 16'd3);
        write_spr(16'hFFFF);
        run_move(4, 1023, 1'b1, 2, 16'd0);
        write_spr(16'd2048);
        run_move(2, 1023, 1'b1, 0, 16'd0);
        write_spr(16'hFFFF);
        run_move(1, 16, 1'b0, 0, 16'd0);
        // Zero register while idle: refused start and idle tick
        write_spr(16'd0);
        push_item(stp_pkg::OP_START, 32'd5, 10'd0, 1'b0);
        random_tick();

        // Random moves under each idling mix
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                    write_spr(16'hFFFF);
                end
                1:
                begin
                    gap_pct = 47;
                    stall_pct = 0;
                    write_spr(16'd2048);
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 47;
                    write_spr(16'($urandom_range(16000, 65535)));
                end
                default:
                begin
                    gap_pct = 17;
                    stall_pct = 17;
                    write_spr(16'hFFFF);
                end
            endcase
            phase_spr = cur_spr;
            phase_end = sent_cnt + 400;
            while (sent_cnt < phase_end)
            begin
                pick = $urandom_range(0, 99);
                m_eff = (cur_spr == 16'd0) ? 1 : cur_spr;
                speed_min = 1000000 / m_eff + 1;
                if (pick < 70 && speed_min <= 1023)
                begin
                    spd = ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(speed_min, 1023);
                    span = ticks_per_step(cur_spr, spd);
                    cnt = $urandom_range(1, (span >= 64) ? 1 : 64 / span);
                    if (cnt * span > 1 && $urandom_range(0, 4) == 0)
                    begin
                        run_move(cnt, spd, 1'($urandom_range(0, 1)),
                                 $urandom_range(1, cnt * span - 1), pick_modulus());
                        write_spr(phase_spr);
                    end
                    else
                        run_move(cnt, spd, 1'($urandom_range(0, 1)), 0, 16'd0);
                end
                else if (pick < 80)
                    random_tick();
                else if (pick < 87)
                    push_item(stp_pkg::OP_START, $urandom, 10'd0, 1'($urandom_range(0, 1)));
                else if (pick < 93)
                    push_item(stp_pkg::OP_START, 32'd0, 10'($urandom_range(1, 1023)),
                              1'($urandom_range(0, 1)));
                else if (pick < 97)
                    settle();
                else
                begin
                    write_spr(pick_modulus());
                    phase_spr = cur_spr;
                end
            end
        end

        // Drain, then give the block time to show any stray result
        settle();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && exp_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ stepper_full_step_sequencer.f @@
src/stp_pkg.sv
src/stp_ctrl.sv
src/stp_dp.sv
src/stepper_full_step_sequencer.sv
tb/coil_motion_checker.sv
tb/tb_stepper_full_step_sequencer.sv
